// File: rtl/core/hss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants of the harmony search step engine.
// ----------------------------------------------------------------------------
package hss_pkg;

  typedef logic signed [25:0] coord_t;
  typedef logic [47:0]        fit_t;

  localparam int ElemXW = 7;  // element index width, covers up to 128 coordinates

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRIAL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] CFG_CONSIDER = 3'd0;
  localparam logic [2:0] CFG_PITCH    = 3'd1;
  localparam logic [2:0] CFG_BW       = 3'd2;
  localparam logic [2:0] CFG_VMIN     = 3'd3;
  localparam logic [2:0] CFG_VMAX     = 3'd4;

  localparam fit_t FIT_MAX = '1;

endpackage
`default_nettype wire

// File: rtl/core/hss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hss_in_if / hss_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hss_in_if import hss_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  slot;
  logic [3:0]  element;
  coord_t      fresh_value;
  logic signed [15:0] pitch_fraction;
  logic [15:0] consider_draw;
  logic [15:0] pitch_draw;

  modport source (output valid, action, slot, element, fresh_value, pitch_fraction,
                  consider_draw, pitch_draw, input ready);
  modport sink (input valid, action, slot, element, fresh_value, pitch_fraction,
                consider_draw, pitch_draw, output ready);
endinterface

interface hss_out_if import hss_pkg::*; ();
  logic       valid;
  logic       ready;
  fit_t       fitness;
  logic       replaced;
  logic [9:0] replaced_slot;
  fit_t       best_fitness;
  logic       improved;
  coord_t     best_value;

  modport source (output valid, fitness, replaced, replaced_slot, best_fitness,
                  improved, best_value, input ready);
  modport sink (input valid, fitness, replaced, replaced_slot, best_fitness,
                improved, best_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hss_slot_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hss_slot_reduce
// Reduction of a 10-bit slot modulo the memory size by reciprocal multiply.
// ----------------------------------------------------------------------------
module hss_slot_reduce import hss_pkg::*; #(
  parameter int MEMORY_SIZE = 1024,
  parameter int SW = $clog2(MEMORY_SIZE)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [9:0]    value,
  output logic               done,
  output logic [SW-1:0]      result
);

  // a slot below 1024 never reaches a larger memory size, so cap the divisor
  localparam int MOD_C = (MEMORY_SIZE >= 1024) ? 1024 : MEMORY_SIZE;
  localparam int RECIP = ((1 << 20) + MOD_C - 1) / MOD_C;

  logic [29:0] prod;
  logic [9:0]  quo;
  logic [9:0]  back;
  logic [9:0]  rem_c;

  // quotient is exact for every 10-bit value with a 20-bit reciprocal
  always_comb begin
    prod  = 30'(value) * 30'(RECIP);
    quo   = prod[29:20];
    back  = quo * 10'(MOD_C);
    rem_c = value - back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      result <= '0;
    end else begin
      done <= start;
      if (start) begin
        result <= SW'(rem_c);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hss_rosen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hss_rosen
// Pipelined Rosenbrock term and saturating running sum over one vector.
// ----------------------------------------------------------------------------
module hss_rosen import hss_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   first,
  input  wire coord_t x,
  output logic        done,
  output fit_t        sum
);

  coord_t      prev;
  coord_t      pr;
  coord_t      cr;
  logic [3:0]  v;
  logic [51:0] ap_sq;
  logic [53:0] ae_sq;
  logic [30:0] ad;
  logic [61:0] ad_sq;

  logic [25:0]        ap;
  logic signed [26:0] ae_s;
  logic [26:0]        ae;
  logic signed [32:0] d;
  logic [52:0]        term;
  logic [52:0]        total;

  always_comb begin
    ap    = pr[25] ? 26'(-$signed({pr[25], pr})) : 26'(pr);
    ae_s  = 27'sd1048576 - 27'(pr);
    ae    = ae_s[26] ? 27'(-ae_s) : 27'(ae_s);
    d     = $signed({{7{cr[25]}}, cr}) - $signed({1'b0, ap_sq[51:20]});
    term  = 53'(ad_sq[61:20]) * 53'd100 + 53'(ae_sq[53:20]);
    total = {5'b0, sum} + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      sum  <= '0;
      v    <= '0;
      done <= 1'b0;
    end else begin
      done <= (start && first) || v[3];
      v    <= {v[2:0], start && !first};
      if (start) begin
        prev <= x;
        if (!first) begin
          pr <= prev;
          cr <= x;
        end
      end
      if (v[0]) begin
        ap_sq <= 52'(ap) * 52'(ap);
        ae_sq <= 54'(ae) * 54'(ae);
      end
      if (v[1]) begin
        ad <= d[32] ? 31'(-d) : 31'(d);
      end
      if (v[2]) begin
        ad_sq <= 62'(ad) * 62'(ad);
      end
      if (start && first) begin
        sum <= '0;
      end else if (v[3]) begin
        sum <= (total > 53'(FIT_MAX)) ? FIT_MAX : total[47:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/harmony_search_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// harmony_search_step
// Harmony search step engine for Rosenbrock minimization, host-supplied draws.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch, one coordinate each; results leave on out_ch.
// Load items fill the harmony memory, trial items build a candidate vector,
// read items return one coordinate of the best vector. A load or trial item
// gives a result only on the last coordinate; a read always answers.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
// One item is worked at a time. A load or trial coordinate keeps the engine
// busy after its transfer for the slot reduction, forming the memory base,
// addressing the harmony memory, reading it for a copied coordinate, and the
// Rosenbrock pipeline. A last trial coordinate adds a scan of the fitness
// memory and, on replacement, a write-back of the trial into the harmony
// memory. A last load into slot 0 adds a copy of it into the best vector.
// Every result, a read's too, passes through the emit state into the output
// register, which it enters once that register is free.
// The result sits in an output register; the next item is taken while it
// waits, and the engine holds its next result until the receiver takes it.
// Reset sets the configuration defaults, best fitness to all ones and clears
// control state; the memories need no clearing.
// ----------------------------------------------------------------------------
module harmony_search_step import hss_pkg::*; #(
  parameter int MEMORY_SIZE = 1024,
  parameter int DIMENSIONS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [25:0] cfg_data,
  hss_in_if.sink           in_ch,
  hss_out_if.source        out_ch
);

  localparam int SW = $clog2(MEMORY_SIZE);
  localparam int EW = $clog2(DIMENSIONS);
  localparam int AW = $clog2(MEMORY_SIZE * DIMENSIONS);
  localparam int CW = $clog2(((MEMORY_SIZE > DIMENSIONS) ? MEMORY_SIZE : DIMENSIONS) + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MOD    = 4'd1;
  localparam logic [3:0] ST_BASE   = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_RD     = 4'd4;
  localparam logic [3:0] ST_ROSEN  = 4'd5;
  localparam logic [3:0] ST_BCOPY  = 4'd6;
  localparam logic [3:0] ST_SCAN   = 4'd7;
  localparam logic [3:0] ST_DECIDE = 4'd8;
  localparam logic [3:0] ST_WCOPY  = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;

  // configuration
  logic [16:0] consider_rate;
  logic [16:0] pitch_rate;
  logic [24:0] bandwidth;
  coord_t      var_min;
  coord_t      var_max;

  // memories
  coord_t harmony_mem [MEMORY_SIZE*DIMENSIONS];
  fit_t   fitness_mem [MEMORY_SIZE];
  coord_t h_rd;
  fit_t   f_rd;
  logic          h_we;
  logic [AW-1:0] h_waddr;
  logic [AW-1:0] h_raddr;
  coord_t        h_wdata;
  logic          f_we;
  logic [SW-1:0] f_waddr;
  logic [SW-1:0] f_raddr;
  fit_t          f_wdata;

  // small register arrays
  coord_t best_vector [DIMENSIONS];
  coord_t trial_vec   [DIMENSIONS];

  // control state
  logic [3:0]        state;
  logic [1:0]        a_act;
  logic [ElemXW-1:0] a_elem;
  coord_t            a_fresh;
  logic signed [15:0] a_pf;
  logic [15:0]       a_cd;
  logic [15:0]       a_pd;
  logic [SW-1:0]     slot_sel;
  logic [SW-1:0]     source_slot;
  logic              copy_flag;
  logic              shift_flag;
  logic [AW-1:0]     base;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cm1;
  logic [SW-1:0]     worst;
  fit_t              worst_fit;
  fit_t              best_score;
  logic signed [26:0] shift_amt;
  logic signed [41:0] shift_prod;

  // pending result
  fit_t       r_fitness;
  logic       r_replaced;
  logic [9:0] r_rslot;
  logic       r_improved;
  coord_t     r_best_value;

  // output register
  logic       out_valid;
  fit_t       o_fitness;
  logic       o_replaced;
  logic [9:0] o_rslot;
  fit_t       o_best_fitness;
  logic       o_improved;
  coord_t     o_best_value;

  // units
  logic          m_start;
  logic          m_done;
  logic [SW-1:0] m_result;
  logic          r_start;
  logic          r_first;
  coord_t        r_x;
  logic          r_done;
  fit_t          r_sum;

  logic [ElemXW-1:0] in_elem;
  logic              accept;
  logic [EW-1:0]     idx;
  logic              last;
  logic signed [27:0] x_sum;
  coord_t            x_shift;
  coord_t            x_copy;

  hss_slot_reduce #(.MEMORY_SIZE(MEMORY_SIZE), .SW(SW)) u_reduce (
    .clk    (clk),
    .rst    (rst),
    .start  (m_start),
    .value  (in_ch.slot),
    .done   (m_done),
    .result (m_result)
  );

  hss_rosen u_rosen (
    .clk   (clk),
    .rst   (rst),
    .start (r_start),
    .first (r_first),
    .x     (r_x),
    .done  (r_done),
    .sum   (r_sum)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_elem     = ElemXW'(in_ch.element);
  assign idx         = a_elem[EW-1:0];
  assign last        = (a_elem == ElemXW'(DIMENSIONS - 1));
  assign cm1         = cnt - CW'(1);

  // full-width product; bits above 15 give the floor of the division by 32768
  assign shift_prod  = $signed({1'b0, bandwidth}) * a_pf;

  assign out_ch.valid         = out_valid;
  assign out_ch.fitness       = o_fitness;
  assign out_ch.replaced      = o_replaced;
  assign out_ch.replaced_slot = o_rslot;
  assign out_ch.best_fitness  = o_best_fitness;
  assign out_ch.improved      = o_improved;
  assign out_ch.best_value    = o_best_value;

  // pitch shift on a copied coordinate, then clamp in the crossed-bound order
  always_comb begin
    x_sum = 28'(h_rd) + 28'(shift_amt);
    if (x_sum < 28'(var_min)) begin
      x_shift = var_min;
    end else if (x_sum > 28'(var_max)) begin
      x_shift = var_max;
    end else begin
      x_shift = x_sum[25:0];
    end
    x_copy = shift_flag ? x_shift : h_rd;
  end

  // memory port and unit control
  always_comb begin
    h_we    = 1'b0;
    h_waddr = base + AW'(idx);
    h_wdata = a_fresh;
    h_raddr = base + AW'(idx);
    f_we    = 1'b0;
    f_waddr = slot_sel;
    f_wdata = r_sum;
    f_raddr = cnt[SW-1:0];
    m_start = accept && (in_ch.action == ACT_LOAD || in_ch.action == ACT_TRIAL);
    r_start = 1'b0;
    r_first = (a_elem == '0);
    r_x     = a_fresh;
    case (state)
      ST_ADDR: begin
        if (a_act == ACT_LOAD) begin
          h_we    = 1'b1;
          r_start = 1'b1;
        end else if (!copy_flag) begin
          r_start = 1'b1;
        end
      end
      ST_RD: begin
        r_start = 1'b1;
        r_x     = x_copy;
      end
      ST_ROSEN: begin
        f_we = r_done && last && (a_act == ACT_LOAD);
      end
      ST_BCOPY: begin
        h_raddr = base + AW'(cnt);
      end
      ST_DECIDE: begin
        f_we    = (r_sum < worst_fit);
        f_waddr = worst;
      end
      ST_WCOPY: begin
        h_we    = 1'b1;
        h_waddr = base + AW'(cnt);
        h_wdata = trial_vec[cnt[EW-1:0]];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      harmony_mem[h_waddr] <= h_wdata;
    end
    h_rd <= harmony_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fitness_mem[f_waddr] <= f_wdata;
    end
    f_rd <= fitness_mem[f_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      consider_rate <= 17'd58982;
      pitch_rate    <= 17'd19661;
      bandwidth     <= 25'd10486;
      var_min       <= -26'sd5242880;
      var_max       <= 26'sd10485760;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONSIDER: consider_rate <= cfg_data[16:0];
        CFG_PITCH:    pitch_rate    <= cfg_data[16:0];
        CFG_BW:       bandwidth     <= cfg_data[24:0];
        CFG_VMIN:     var_min       <= cfg_data;
        CFG_VMAX:     var_max       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      copy_flag   <= 1'b0;
      shift_flag  <= 1'b0;
      source_slot <= '0;
      best_score  <= FIT_MAX;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      // free the output register after its transfer unless a result refills it
      if (out_valid && out_ch.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            a_act   <= in_ch.action;
            a_elem  <= in_elem;
            a_fresh <= in_ch.fresh_value;
            a_pf    <= in_ch.pitch_fraction;
            a_cd    <= in_ch.consider_draw;
            a_pd    <= in_ch.pitch_draw;
            if (in_ch.action == ACT_READ) begin
              r_fitness  <= '0;
              r_replaced <= 1'b0;
              r_rslot    <= '0;
              r_improved <= 1'b0;
              r_best_value <= (in_elem < ElemXW'(DIMENSIONS)) ?
                              best_vector[in_elem[EW-1:0]] : '0;
              state <= ST_EMIT;
            end else if ((in_ch.action == ACT_LOAD || in_ch.action == ACT_TRIAL) &&
                         in_elem < ElemXW'(DIMENSIONS)) begin
              state <= ST_MOD;
            end
            // unknown action or element out of range: drop
          end
        end
        ST_MOD: begin
          if (m_done) begin
            if (a_act == ACT_LOAD) begin
              slot_sel <= m_result;
            end else if (a_elem == '0) begin
              copy_flag   <= (17'(a_cd) < consider_rate);
              shift_flag  <= (17'(a_cd) < consider_rate) && (17'(a_pd) < pitch_rate);
              source_slot <= m_result;
              slot_sel    <= m_result;
            end else begin
              slot_sel <= source_slot;
            end
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          base  <= AW'(slot_sel * DIMENSIONS);
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          shift_amt <= shift_prod[41:15];
          if (a_act == ACT_LOAD) begin
            state <= ST_ROSEN;
          end else if (copy_flag) begin
            state <= ST_RD;
          end else begin
            trial_vec[idx] <= a_fresh;
            state <= ST_ROSEN;
          end
        end
        ST_RD: begin
          trial_vec[idx] <= x_copy;
          state <= ST_ROSEN;
        end
        ST_ROSEN: begin
          if (r_done) begin
            if (!last) begin
              state <= ST_IDLE;
            end else if (a_act == ACT_LOAD) begin
              r_fitness  <= r_sum;
              r_replaced <= 1'b0;
              r_rslot    <= '0;
              r_improved <= 1'b0;
              r_best_value <= '0;
              cnt <= '0;
              if (slot_sel == '0) begin
                best_score <= r_sum;
                state <= ST_BCOPY;
              end else begin
                state <= ST_EMIT;
              end
            end else begin
              cnt   <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_BCOPY: begin
          // base holds slot 0; read one coordinate a cycle, store one behind
          if (cnt != '0) begin
            best_vector[cm1[EW-1:0]] <= h_rd;
          end
          if (cnt == CW'(DIMENSIONS)) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_SCAN: begin
          // strict compare keeps the lowest-indexed worst entry
          if (cnt != '0) begin
            if (cnt == CW'(1) || f_rd > worst_fit) begin
              worst_fit <= f_rd;
              worst     <= cm1[SW-1:0];
            end
          end
          if (cnt == CW'(MEMORY_SIZE)) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_DECIDE: begin
          r_fitness    <= r_sum;
          r_replaced   <= (r_sum < worst_fit);
          r_rslot      <= 10'(worst);
          r_improved   <= (r_sum < best_score);
          r_best_value <= '0;
          if (r_sum < best_score) begin
            best_score <= r_sum;
            for (int i = 0; i < DIMENSIONS; i++) begin
              best_vector[i] <= trial_vec[i];
            end
          end
          base <= AW'(worst * DIMENSIONS);
          cnt  <= '0;
          state <= (r_sum < worst_fit) ? ST_WCOPY : ST_EMIT;
        end
        ST_WCOPY: begin
          if (cnt == CW'(DIMENSIONS - 1)) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid      <= 1'b1;
            o_fitness      <= r_fitness;
            o_replaced     <= r_replaced;
            o_rslot        <= r_rslot;
            o_best_fitness <= best_score;
            o_improved     <= r_improved;
            o_best_value   <= r_best_value;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
